// File: hw/rtl/dvtu_pkg.sv
// ----------------------------------------------------------------------------
// dvtu_pkg
// Types, constants and the control store of the distance-vector table
// update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dvtu_pkg;

  // Table geometry and field widths
  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdWidth    = 8;
  localparam int unsigned IdxWidth   = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntWidth   = $clog2(TableDepth + 1);
  localparam int unsigned CostWidth  = 16;
  localparam int unsigned IdFieldW   = 8;

  localparam logic [CostWidth-1:0] CostMax = '1;
  localparam logic [CntWidth-1:0]  CountFull = CntWidth'(TableDepth);

  // Input word
  typedef struct packed {
    logic                 kind;
    logic [IdFieldW-1:0]  sender_id;
    logic [CostWidth-1:0] link_cost;
    logic [IdFieldW-1:0]  dest_id;
    logic [CostWidth-1:0] advertised_cost;
  } req_t;

  // Result word
  typedef struct packed {
    logic                 changed;
    logic                 table_full;
    logic [CostWidth-1:0] route_cost;
    logic [IdFieldW-1:0]  route_next_hop;
  } res_t;

  // One routing table entry as held in the RAM
  typedef struct packed {
    logic [IdWidth-1:0]   dest;
    logic [CostWidth-1:0] cost;
    logic [IdWidth-1:0]   hop;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

  // Kind of input word
  localparam logic KindLink = 1'b0;

  // Microcode: datapath operations
  typedef enum logic [2:0] {
    OpNone   = 3'd0,
    OpPrep   = 3'd1,
    OpScan   = 3'd2,
    OpUpdate = 3'd3,
    OpAppend = 3'd4,
    OpReport = 3'd5
  } uc_op_e;

  // Microcode: jump conditions
  typedef enum logic [2:0] {
    CondNever  = 3'd0,
    CondStart  = 3'd1,
    CondSelf   = 3'd2,
    CondHit    = 3'd3,
    CondMissed = 3'd4
  } uc_cond_e;

  typedef logic [2:0] uc_addr_t;

  // Microcode addresses
  localparam uc_addr_t UcIdle   = 3'd0;
  localparam uc_addr_t UcPrep   = 3'd1;
  localparam uc_addr_t UcScan   = 3'd2;
  localparam uc_addr_t UcDecide = 3'd3;
  localparam uc_addr_t UcUpdate = 3'd4;
  localparam uc_addr_t UcAppend = 3'd5;
  localparam uc_addr_t UcReport = 3'd6;

  typedef struct packed {
    uc_op_e   op;
    uc_cond_e cond;
    uc_addr_t jump;
    uc_addr_t next;
  } uc_word_t;

  // Control store: jump when the condition holds, else go to next
  function automatic uc_word_t uc_rom(uc_addr_t addr);
    uc_word_t w;
    unique case (addr)
      UcIdle:   w = '{op: OpNone,   cond: CondStart,  jump: UcPrep,   next: UcIdle};
      UcPrep:   w = '{op: OpPrep,   cond: CondSelf,   jump: UcReport, next: UcScan};
      UcScan:   w = '{op: OpScan,   cond: CondHit,    jump: UcDecide, next: UcScan};
      UcDecide: w = '{op: OpNone,   cond: CondMissed, jump: UcAppend, next: UcUpdate};
      UcUpdate: w = '{op: OpUpdate, cond: CondNever,  jump: UcIdle,   next: UcReport};
      UcAppend: w = '{op: OpAppend, cond: CondNever,  jump: UcIdle,   next: UcReport};
      UcReport: w = '{op: OpReport, cond: CondNever,  jump: UcIdle,   next: UcIdle};
      default:  w = '{op: OpNone,   cond: CondNever,  jump: UcIdle,   next: UcIdle};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dvtu_ram.sv
// ----------------------------------------------------------------------------
// dvtu_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dvtu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                      wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write, and register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/distance_vector_table_update_unit.sv
// ----------------------------------------------------------------------------
// distance_vector_table_update_unit
// Routing table of one node: installs direct links and merges advertised
// distance-vector entries, driven by a small microprogram.
// ----------------------------------------------------------------------------
// Sequence: accept, prepare, scan the entries up to the matching index (or the
// fill count on a miss), decide, update or append, report, then the done_o
// strobe; a word naming this node goes from prepare straight to report.
// Throughput: one word at a time; the search reads one entry a cycle from the
// single read port of the table RAM. A new word is taken in the strobe cycle.
// Reset empties the table and clears own_id; results cannot be stalled.
`default_nettype none

module distance_vector_table_update_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  input  wire dvtu_pkg::req_t              req_i,
  output logic                             busy,
  output logic                             done_o,
  output dvtu_pkg::res_t                   res_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [dvtu_pkg::IdFieldW-1:0] cfg_data_i
);

  localparam int unsigned IdW  = dvtu_pkg::IdWidth;
  localparam int unsigned IdxW = dvtu_pkg::IdxWidth;
  localparam int unsigned CntW = dvtu_pkg::CntWidth;
  localparam int unsigned CstW = dvtu_pkg::CostWidth;

  // Sequencer
  dvtu_pkg::uc_addr_t pc_q, pc_d;
  dvtu_pkg::uc_word_t uw;
  logic               cond_ok;

  // Datapath registers
  logic [dvtu_pkg::IdFieldW-1:0] own_id_q;
  dvtu_pkg::req_t                req_q;
  logic [IdW-1:0]                dest_q;
  logic [CstW-1:0]               cost_q;
  logic [CntW-1:0]               count_q;
  logic [CntW-1:0]               cur_q;
  logic                          miss_q;
  dvtu_pkg::entry_t              entry_q;
  dvtu_pkg::res_t                res_q;
  logic                          done_q;

  // Datapath wires
  logic                          accept;
  logic                          is_self;
  logic                          scan_end;
  logic                          scan_match;
  logic [CstW:0]                 sum;
  logic [IdW-1:0]                sender;
  logic                          take;
  logic                          ram_we;
  logic [IdxW-1:0]               ram_waddr;
  logic [IdxW-1:0]               ram_raddr;
  logic [CntW-1:0]               cur_inc;
  dvtu_pkg::entry_t              ram_wdata;
  dvtu_pkg::entry_t              ram_rdata;

  assign accept      = start && !busy;
  assign busy        = (pc_q != dvtu_pkg::UcIdle);
  assign cfg_ready_o = !busy;
  assign done_o      = done_q;
  assign res_o       = res_q;

  assign uw         = dvtu_pkg::uc_rom(pc_q);
  assign sender     = req_q.sender_id[IdW-1:0];
  assign is_self    = (dest_q == own_id_q[IdW-1:0]);
  assign scan_end   = (cur_q == count_q);
  assign scan_match = (ram_rdata.dest == dest_q);
  assign sum        = {1'b0, req_q.link_cost} + {1'b0, req_q.advertised_cost};
  assign take       = (req_q.kind == dvtu_pkg::KindLink) || (cost_q < entry_q.cost);
  assign cur_inc    = cur_q + CntW'(1);

  // Pick the jump condition
  always_comb begin
    unique case (uw.cond)
      dvtu_pkg::CondNever:  cond_ok = 1'b0;
      dvtu_pkg::CondStart:  cond_ok = start;
      dvtu_pkg::CondSelf:   cond_ok = is_self;
      dvtu_pkg::CondHit:    cond_ok = scan_end || scan_match;
      dvtu_pkg::CondMissed: cond_ok = miss_q;
      default:              cond_ok = 1'b0;
    endcase
    pc_d = cond_ok ? uw.jump : uw.next;
  end

  // Table RAM addressing: prefetch the next entry while scanning
  always_comb begin
    ram_raddr = cur_inc[IdxW-1:0];
    if (uw.op == dvtu_pkg::OpPrep) begin
      ram_raddr = '0;
    end
    ram_we    = 1'b0;
    ram_waddr = cur_q[IdxW-1:0];
    ram_wdata = '{dest: dest_q, cost: cost_q, hop: sender};
    if (uw.op == dvtu_pkg::OpUpdate) begin
      ram_we = take;
    end else if (uw.op == dvtu_pkg::OpAppend) begin
      ram_we    = (count_q != dvtu_pkg::CountFull);
      ram_waddr = count_q[IdxW-1:0];
    end
  end

  dvtu_ram #(
    .Width (dvtu_pkg::EntryWidth),
    .Depth (dvtu_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Advance the microprogram, hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= dvtu_pkg::UcIdle;
      own_id_q <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      done_q <= (uw.op == dvtu_pkg::OpReport);
      if (cfg_valid_i && cfg_ready_o) begin
        own_id_q <= cfg_data_i;
      end
      if ((uw.op == dvtu_pkg::OpAppend) && (count_q != dvtu_pkg::CountFull)) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  // Datapath: latch the word, form the cost, scan and merge
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_i;
      dest_q <= (req_i.kind == dvtu_pkg::KindLink) ? req_i.sender_id[IdW-1:0]
                                                   : req_i.dest_id[IdW-1:0];
    end
    unique case (uw.op)
      dvtu_pkg::OpPrep: begin
        cur_q <= '0;
        res_q <= '0;
        if (req_q.kind == dvtu_pkg::KindLink) begin
          cost_q <= req_q.link_cost;
        end else if (sum[CstW]) begin
          cost_q <= dvtu_pkg::CostMax;
        end else begin
          cost_q <= sum[CstW-1:0];
        end
      end
      dvtu_pkg::OpScan: begin
        entry_q <= ram_rdata;
        miss_q  <= scan_end;
        if (!scan_end && !scan_match) begin
          cur_q <= cur_inc;
        end
      end
      dvtu_pkg::OpUpdate: begin
        if (take) begin
          res_q.changed        <= (entry_q.cost != cost_q) || (entry_q.hop != sender);
          res_q.route_cost     <= cost_q;
          res_q.route_next_hop <= dvtu_pkg::IdFieldW'(sender);
        end else begin
          res_q.route_cost     <= entry_q.cost;
          res_q.route_next_hop <= dvtu_pkg::IdFieldW'(entry_q.hop);
        end
      end
      dvtu_pkg::OpAppend: begin
        if (count_q != dvtu_pkg::CountFull) begin
          res_q.changed        <= 1'b1;
          res_q.route_cost     <= cost_q;
          res_q.route_next_hop <= dvtu_pkg::IdFieldW'(sender);
        end else begin
          res_q.table_full <= 1'b1;
        end
      end
      dvtu_pkg::OpNone, dvtu_pkg::OpReport: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: tb/route_table_checker.sv
// ----------------------------------------------------------------------------
// route_table_checker
// Watches the word, result and own_id channels of the distance-vector table
// update unit. It keeps its own copy of the routing table and predicts each
// result, then compares every result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module route_table_checker
  import dvtu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  req_t                req_i,
  input  logic                done_i,
  input  res_t                res_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [IdFieldW-1:0] cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_count_o,
  output int unsigned         result_count_o
);

  // Shadow copy of the node's routing table
  logic [IdWidth-1:0]  node_id;
  entry_t              routes [TableDepth];
  logic [CntWidth-1:0] route_count;

  // Route reports still owed by the block, oldest first
  res_t route_reports [$];
  res_t wanted;
  res_t seen;

  // Apply one word to the shadow table and return the route it reports
  function automatic res_t update_route(input req_t w);
    logic [IdWidth-1:0]   target;
    logic [IdWidth-1:0]   hop;
    logic [CostWidth:0]   sum;
    logic [CostWidth-1:0] offer;
    int                   slot;
    int                   i;
    res_t                 r;
    r   = '0;
    hop = w.sender_id[IdWidth-1:0];
    if (w.kind == KindLink) begin
      target = hop;
      offer  = w.link_cost;
    end else begin
      target = w.dest_id[IdWidth-1:0];
      sum    = {1'b0, w.link_cost} + {1'b0, w.advertised_cost};
      offer  = sum[CostWidth] ? CostMax : sum[CostWidth-1:0];
    end
    // Drop routes to this node itself
    if (target == node_id) return r;
    slot = -1;
    for (i = 0; i < int'(route_count); i++) begin
      if (slot < 0 && routes[i].dest == target) slot = i;
    end
    if (slot < 0) begin
      if (route_count < CountFull) begin
        routes[route_count[IdxWidth-1:0]] = '{dest: target, cost: offer, hop: hop};
        route_count         = route_count + 1'b1;
        r.changed           = 1'b1;
        r.route_cost        = offer;
        r.route_next_hop    = IdFieldW'(hop);
      end else begin
        r.table_full = 1'b1;
      end
    end else begin
      // A direct link always wins; an advert only when strictly cheaper
      if (w.kind == KindLink || offer < routes[slot].cost) begin
        if (routes[slot].cost != offer || routes[slot].hop != hop) r.changed = 1'b1;
        routes[slot].cost = offer;
        routes[slot].hop  = hop;
      end
      r.route_cost     = routes[slot].cost;
      r.route_next_hop = IdFieldW'(routes[slot].hop);
    end
    return r;
  endfunction

  // Track register writes, check results, then predict new words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id         = '0;
      route_count     = '0;
      route_reports.delete();
      fail_count_o    = 0;
      pending_count_o = 0;
      result_count_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) node_id = cfg_data_i[IdWidth-1:0];

      if (done_i) begin
        result_count_o++;
        if (route_reports.size() == 0) begin
          $error("result word with no route report outstanding: %h", res_i);
          fail_count_o++;
        end else begin
          wanted = route_reports.pop_front();
          seen   = res_i;
          if (seen.changed !== wanted.changed) begin
            $error("changed: expected %0d, got %0d", wanted.changed, seen.changed);
            fail_count_o++;
          end
          if (seen.table_full !== wanted.table_full) begin
            $error("table_full: expected %0d, got %0d", wanted.table_full, seen.table_full);
            fail_count_o++;
          end
          if (seen.route_cost !== wanted.route_cost) begin
            $error("route_cost: expected %0d, got %0d", wanted.route_cost, seen.route_cost);
            fail_count_o++;
          end
          if (seen.route_next_hop !== wanted.route_next_hop) begin
            $error("route_next_hop: expected %0d, got %0d",
                   wanted.route_next_hop, seen.route_next_hop);
            fail_count_o++;
          end
        end
      end

      if (start_i && !busy_i) route_reports.push_back(update_route(req_i));
      pending_count_o = route_reports.size();
    end
  end

endmodule

// File: tb/distance_vector_table_update_unit_test.sv
// ----------------------------------------------------------------------------
// distance_vector_table_update_unit_test
// Drives direct-link and advertised words into the table update unit under
// several own_id settings, with random gaps on the word and register
// channels. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module distance_vector_table_update_unit_test;
  import dvtu_pkg::*;

  localparam logic        KindAdvert = ~KindLink;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PoolSize   = 64;
  localparam int unsigned PoolIdxW   = $clog2(PoolSize);
  localparam int unsigned DrainWait  = 40;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  req_t                req_i;
  logic                busy;
  logic                done_o;
  res_t                res_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [IdFieldW-1:0] cfg_data_i;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned result_count;
  int unsigned cycle_count;
  int unsigned word_count;
  int unsigned setting_count;
  int unsigned idle_pct;

  logic [IdFieldW-1:0] node_id;
  logic [IdFieldW-1:0] id_pool [PoolSize];

  distance_vector_table_update_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  route_table_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .req_i           (req_i),
    .done_i          (done_o),
    .res_i           (res_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count),
    .result_count_o  (result_count)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a run that hangs
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic req_t make_word(input logic kind, input logic [7:0] sender,
                                     input logic [15:0] link, input logic [7:0] dest,
                                     input logic [15:0] adv);
    req_t w;
    w = '{kind: kind, sender_id: sender, link_cost: link, dest_id: dest,
          advertised_cost: adv};
    return w;
  endfunction

  // Mostly small costs so that routes improve, some full range, some near the top
  function automatic logic [CostWidth-1:0] pick_cost();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return CostWidth'($urandom_range(1, 200));
    if (r < 90) return CostWidth'($urandom_range(0, 65535));
    return CostWidth'($urandom_range(65000, 65535));
  endfunction

  // Well-formed words over a pool of neighbours, with some noise
  function automatic req_t random_word(input int unsigned pool_used);
    req_t w;
    w.kind            = 1'($urandom_range(1));
    w.sender_id       = IdFieldW'($urandom_range(255));
    w.link_cost       = CostWidth'($urandom_range(65535));
    w.dest_id         = IdFieldW'($urandom_range(255));
    w.advertised_cost = CostWidth'($urandom_range(65535));
    if ($urandom_range(99) >= 15) begin
      w.kind      = ($urandom_range(99) < 30) ? KindLink : KindAdvert;
      w.sender_id = id_pool[PoolIdxW'($urandom_range(pool_used - 1))];
      w.link_cost = pick_cost();
      if (w.kind == KindAdvert) begin
        w.dest_id         = id_pool[PoolIdxW'($urandom_range(pool_used - 1))];
        w.advertised_cost = pick_cost();
      end
    end
    // Now and then name this node itself
    if ($urandom_range(99) < 5) begin
      if (w.kind == KindLink) w.sender_id = node_id;
      else w.dest_id = node_id;
    end
    return w;
  endfunction

  // Offer one word, idling first at random; return once it is taken
  task automatic send_word(input req_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    word_count++;
  endtask

  // Write own_id once the block has drained
  task automatic set_node_id(input logic [IdFieldW-1:0] v);
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0 || busy) @(negedge clk_i);
    @(posedge clk_i);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    node_id = v;
    setting_count++;
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned pool_used,
                           input int unsigned quiet);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      idle_pct = (i < quiet) ? 0 : 13;
      send_word(random_word(pool_used));
    end
    idle_pct = 13;
  endtask

  // Stimulus
  initial begin
    int unsigned i;
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    node_id       = '0;
    word_count    = 0;
    setting_count = 0;
    idle_pct      = 13;
    for (i = 0; i < PoolSize; i++) id_pool[i] = IdFieldW'($urandom_range(255));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words with this node as 0
    set_node_id(8'h00);
    send_word(make_word(KindLink,   8'd5,   16'd10,    8'd0,   16'd0));
    // same link again, then a dearer one that still overwrites
    send_word(make_word(KindLink,   8'd5,   16'd10,    8'd0,   16'd0));
    send_word(make_word(KindLink,   8'd5,   16'd20,    8'd0,   16'd0));
    send_word(make_word(KindAdvert, 8'd5,   16'd20,    8'd7,   16'd30));
    // dearer, then equal, then cheaper offers for destination 7
    send_word(make_word(KindAdvert, 8'd9,   16'd1,     8'd7,   16'd100));
    send_word(make_word(KindAdvert, 8'd9,   16'd10,    8'd7,   16'd40));
    send_word(make_word(KindAdvert, 8'd9,   16'd1,     8'd7,   16'd1));
    // saturating sum and a zero cost
    send_word(make_word(KindAdvert, 8'd5,   16'hFFFF,  8'd200, 16'hFFFF));
    send_word(make_word(KindAdvert, 8'd5,   16'd0,     8'd201, 16'd0));
    // words naming this node, then others with edge ids and costs
    send_word(make_word(KindLink,   8'd0,   16'd3,     8'd0,   16'd0));
    send_word(make_word(KindAdvert, 8'd5,   16'd2,     8'd0,   16'd2));
    send_word(make_word(KindLink,   8'd255, 16'hFFFF,  8'hFF,  16'hFFFF));
    send_word(make_word(KindAdvert, 8'd255, 16'd0,     8'd255, 16'd1));
    send_word(make_word(KindLink,   8'd255, 16'd1,     8'd0,   16'd0));
    send_word(make_word(KindAdvert, 8'd128, 16'hFFFF,  8'd5,   16'd1));
    send_word(make_word(KindLink,   8'd9,   16'd1,     8'hFF,  16'hFFFF));
    send_word(make_word(KindAdvert, 8'd7,   16'd1,     8'd9,   16'd0));

    // Random phases: a small pool first, then enough neighbours to fill the table
    set_node_id(8'hFF);
    run_phase(350, 20, 0);
    set_node_id(IdFieldW'($urandom_range(255)));
    run_phase(350, PoolSize, 200);
    set_node_id(id_pool[0]);
    run_phase(350, PoolSize, 0);
    set_node_id(IdFieldW'($urandom_range(255)));
    run_phase(380, PoolSize, 0);

    // Drain and let the block settle
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Checked %0d results from %0d words under %0d own_id settings",
             result_count, word_count, setting_count);
    $display("Covered links, adverts, self routes, saturated sums and a full table");
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/dvtu_pkg.sv
hw/rtl/dvtu_ram.sv
hw/rtl/distance_vector_table_update_unit.sv
tb/route_table_checker.sv
tb/distance_vector_table_update_unit_test.sv
